@@ rtl/tsie_pkg.sv @@
// tsie_pkg: shared types and codes for the token stream instruction encoder
// token and result payloads, parser states, token kinds, status and operand codes
// no dependencies
package tsie_pkg;

  // input token transfer
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  code;
    logic [15:0] number;
  } token_t;

  // output result transfer
  typedef struct packed {
    logic [15:0] word;
    logic [15:0] address;
    logic [3:0]  status;
    logic        last;
  } result_t;

  // all results caused by one token, handed from parser to output queue
  typedef struct packed {
    logic [15:0] word;
    logic [15:0] address;
    logic [3:0]  status;
    logic [1:0]  extra_n;
    logic [15:0] extra0;
    logic [15:0] extra1;
  } group_t;

  // parser states: statement level, then one operand sub-state set per operand
  typedef enum logic [3:0] {
    StStart  = 4'd0,
    StLabel  = 4'd1,
    StComma  = 4'd2,
    StAOpen  = 4'd3,
    StABrack = 4'd4,
    StABreg  = 4'd5,
    StABregc = 4'd6,
    StABregn = 4'd7,
    StABnum  = 4'd8,
    StBOpen  = 4'd9,
    StBBrack = 4'd10,
    StBBreg  = 4'd11,
    StBBregc = 4'd12,
    StBBregn = 4'd13,
    StBBnum  = 4'd14
  } state_e;

  // token kinds
  localparam logic [3:0] KindOpcode = 4'd0;
  localparam logic [3:0] KindReg    = 4'd1;
  localparam logic [3:0] KindPop    = 4'd2;
  localparam logic [3:0] KindO      = 4'd7;
  localparam logic [3:0] KindComma  = 4'd8;
  localparam logic [3:0] KindLbrack = 4'd9;
  localparam logic [3:0] KindRbrack = 4'd10;
  localparam logic [3:0] KindColon  = 4'd11;
  localparam logic [3:0] KindName   = 4'd12;
  localparam logic [3:0] KindNumber = 4'd13;
  localparam logic [3:0] KindEnd    = 4'd14;

  // result status codes
  localparam logic [3:0] StatusWord = 4'd0;
  localparam logic [3:0] StatusEnd  = 4'd1;
  localparam logic [3:0] ErrStmt    = 4'd2;
  localparam logic [3:0] ErrBrack   = 4'd3;
  localparam logic [3:0] ErrOper    = 4'd4;
  localparam logic [3:0] ErrComma   = 4'd5;
  localparam logic [3:0] ErrNumber  = 4'd6;
  localparam logic [3:0] ErrClose   = 4'd7;
  localparam logic [3:0] ErrLabel   = 4'd8;

  // operand field codes
  localparam logic [5:0] OpdRegInd = 6'h08;
  localparam logic [5:0] OpdRegOfs = 6'h10;
  localparam logic [5:0] OpdPop    = 6'h18;
  localparam logic [5:0] OpdLitInd = 6'h1e;
  localparam logic [5:0] OpdLit    = 6'h1f;

  // a result group holds the instruction word and up to this many literal words
  localparam logic [1:0] MaxExtra = 2'd2;

endpackage

@@ rtl/tsie_parser.sv @@
// tsie_parser: statement parser, consumes one token per transfer
// builds the result group of each token and keeps address and literal state
// depends on tsie_pkg
module tsie_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  tsie_pkg::token_t  token_i,
  output logic              push_o,
  output tsie_pkg::group_t  group_o
);

  tsie_pkg::state_e state_q, state_d;
  logic [3:0]  opc_q, opc_d;
  logic [5:0]  a_code_q, a_code_d;
  logic [2:0]  preg_q, preg_d;
  logic [15:0] xw_q [2];
  logic [15:0] xw_d [2];
  logic [1:0]  xcnt_q, xcnt_d;
  logic [15:0] addr_q, addr_d;
  logic        halted_q, halted_d;

  // decode scratch
  logic        is_b;
  logic        lit_push;
  logic        done;
  logic [5:0]  done_code;
  logic        fail;
  logic [3:0]  err;
  logic [2:0]  reg_idx;
  logic [1:0]  xcnt_mid;

  assign reg_idx = token_i.code[2:0];

  // next state and result group
  always_comb begin
    state_d   = state_q;
    opc_d     = opc_q;
    a_code_d  = a_code_q;
    preg_d    = preg_q;
    xw_d      = xw_q;
    xcnt_d    = xcnt_q;
    addr_d    = addr_q;
    halted_d  = halted_q;
    push_o    = 1'b0;
    lit_push  = 1'b0;
    done      = 1'b0;
    done_code = 6'd0;
    fail      = 1'b0;
    err       = tsie_pkg::ErrStmt;
    xcnt_mid  = xcnt_q;
    is_b      = (state_q >= tsie_pkg::StBOpen);
    group_o   = '{word: 16'd0, address: addr_q, status: tsie_pkg::StatusWord,
                  extra_n: 2'd0, extra0: xw_q[0], extra1: xw_q[1]};

    if (accept_i && !halted_q) begin
      unique case (state_q)
        tsie_pkg::StStart: begin
          if (token_i.kind == tsie_pkg::KindEnd) begin
            group_o.status = tsie_pkg::StatusEnd;
            push_o         = 1'b1;
          end else if (token_i.kind == tsie_pkg::KindColon) begin
            state_d = tsie_pkg::StLabel;
          end else if (token_i.kind == tsie_pkg::KindOpcode && token_i.code != 4'd0) begin
            opc_d    = token_i.code;
            xcnt_d   = 2'd0;
            xcnt_mid = 2'd0;
            state_d  = tsie_pkg::StAOpen;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrStmt;
          end
        end
        tsie_pkg::StLabel: begin
          if (token_i.kind == tsie_pkg::KindName) begin
            state_d = tsie_pkg::StStart;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrLabel;
          end
        end
        tsie_pkg::StComma: begin
          if (token_i.kind == tsie_pkg::KindComma) begin
            state_d = tsie_pkg::StBOpen;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrComma;
          end
        end
        tsie_pkg::StAOpen, tsie_pkg::StBOpen: begin
          if (token_i.kind == tsie_pkg::KindReg) begin
            done      = 1'b1;
            done_code = {3'd0, reg_idx};
          end else if (token_i.kind >= tsie_pkg::KindPop && token_i.kind <= tsie_pkg::KindO) begin
            done      = 1'b1;
            done_code = tsie_pkg::OpdPop + {2'd0, token_i.kind - tsie_pkg::KindPop};
          end else if (token_i.kind == tsie_pkg::KindNumber) begin
            lit_push  = 1'b1;
            done      = 1'b1;
            done_code = tsie_pkg::OpdLit;
          end else if (token_i.kind == tsie_pkg::KindLbrack) begin
            state_d = is_b ? tsie_pkg::StBBrack : tsie_pkg::StABrack;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrBrack;
          end
        end
        tsie_pkg::StABrack, tsie_pkg::StBBrack: begin
          if (token_i.kind == tsie_pkg::KindReg) begin
            preg_d  = reg_idx;
            state_d = is_b ? tsie_pkg::StBBreg : tsie_pkg::StABreg;
          end else if (token_i.kind == tsie_pkg::KindNumber) begin
            lit_push = 1'b1;
            state_d  = is_b ? tsie_pkg::StBBnum : tsie_pkg::StABnum;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrOper;
          end
        end
        tsie_pkg::StABreg, tsie_pkg::StBBreg: begin
          if (token_i.kind == tsie_pkg::KindRbrack) begin
            done      = 1'b1;
            done_code = tsie_pkg::OpdRegInd | {3'd0, preg_q};
          end else if (token_i.kind == tsie_pkg::KindComma) begin
            state_d = is_b ? tsie_pkg::StBBregc : tsie_pkg::StABregc;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrOper;
          end
        end
        tsie_pkg::StABregc, tsie_pkg::StBBregc: begin
          if (token_i.kind == tsie_pkg::KindNumber) begin
            lit_push = 1'b1;
            state_d  = is_b ? tsie_pkg::StBBregn : tsie_pkg::StABregn;
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrNumber;
          end
        end
        tsie_pkg::StABregn, tsie_pkg::StBBregn: begin
          if (token_i.kind == tsie_pkg::KindRbrack) begin
            done      = 1'b1;
            done_code = tsie_pkg::OpdRegOfs | {3'd0, preg_q};
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrClose;
          end
        end
        tsie_pkg::StABnum, tsie_pkg::StBBnum: begin
          if (token_i.kind == tsie_pkg::KindRbrack) begin
            done      = 1'b1;
            done_code = tsie_pkg::OpdLitInd;
          end else if (token_i.kind == tsie_pkg::KindReg) begin
            done      = 1'b1;
            done_code = tsie_pkg::OpdRegOfs | {3'd0, reg_idx};
          end else begin
            fail = 1'b1;
            err  = tsie_pkg::ErrOper;
          end
        end
        default: begin
          fail    = 1'b1;
          err     = tsie_pkg::ErrStmt;
          state_d = tsie_pkg::StStart;
        end
      endcase

      // literal word goes to the slot picked by the count, count saturates
      if (lit_push) begin
        xw_d[xcnt_q[0]] = token_i.number;
        if (xcnt_q < tsie_pkg::MaxExtra) begin
          xcnt_mid = xcnt_q + 2'd1;
        end
        xcnt_d = xcnt_mid;
      end

      // operand complete: first one parks its code, second one emits
      if (done) begin
        if (!is_b) begin
          a_code_d = done_code;
          state_d  = tsie_pkg::StComma;
        end else begin
          group_o.word    = {done_code, a_code_q, opc_q};
          group_o.extra_n = xcnt_mid;
          group_o.extra0  = xw_d[0];
          group_o.extra1  = xw_d[1];
          push_o          = 1'b1;
          addr_d          = addr_q + 16'd1 + {14'd0, xcnt_mid};
          xcnt_d          = 2'd0;
          state_d         = tsie_pkg::StStart;
        end
      end

      // syntax error: one status result, then halt until reset
      if (fail) begin
        group_o.status = err;
        push_o         = 1'b1;
        halted_d       = 1'b1;
      end
    end
  end

  // control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tsie_pkg::StStart;
      opc_q    <= 4'd0;
      a_code_q <= 6'd0;
      preg_q   <= 3'd0;
      xcnt_q   <= 2'd0;
      addr_q   <= 16'd0;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      opc_q    <= opc_d;
      a_code_q <= a_code_d;
      preg_q   <= preg_d;
      xcnt_q   <= xcnt_d;
      addr_q   <= addr_d;
      halted_q <= halted_d;
    end
  end

  // literal words, no reset
  always_ff @(posedge clk_i) begin
    xw_q <= xw_d;
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("parser left halt without reset");

  a_no_push_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o)
    else $error("parser produced a result while halted");

  a_literal_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsie_pkg::StStart || state_q == tsie_pkg::StLabel) |-> xcnt_q == 2'd0)
    else $error("literal count not cleared between statements");
`endif

endmodule

@@ rtl/tsie_out_queue.sv @@
// tsie_out_queue: two-entry queue of result groups and output sequencer
// sends each group's results one per transfer, instruction word first
// depends on tsie_pkg
module tsie_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tsie_pkg::group_t   group_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsie_pkg::result_t  out_data_o
);

  tsie_pkg::group_t grp_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic [1:0]       idx_q;
  tsie_pkg::group_t head;
  logic             pop;
  logic             head_done;

  assign head        = grp_q[rd_ptr_q];
  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_done   = (idx_q == head.extra_n);

  // result selection within the head group
  always_comb begin
    out_data_o.address = head.address + {14'd0, idx_q};
    out_data_o.last    = head_done;
    unique case (idx_q)
      2'd0: begin
        out_data_o.word   = head.word;
        out_data_o.status = head.status;
      end
      2'd1: begin
        out_data_o.word   = head.extra0;
        out_data_o.status = tsie_pkg::StatusWord;
      end
      default: begin
        out_data_o.word   = head.extra1;
        out_data_o.status = tsie_pkg::StatusWord;
      end
    endcase
  end

  // pointers, fill count and position within the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        if (head_done) begin
          rd_ptr_q <= ~rd_ptr_q;
          idx_q    <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop && head_done};
    end
  end

  // group storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      grp_q[wr_ptr_q] <= group_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q <= head.extra_n)
    else $error("result index beyond head group");

  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> idx_q == 2'd0)
    else $error("result index not cleared on empty queue");
`endif

endmodule

@@ rtl/token_stream_instruction_encoder.sv @@
// token_stream_instruction_encoder: top level, parser plus output queue
// depends on tsie_pkg, tsie_parser, tsie_out_queue
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o    | tsie_pkg::token_t
//   out     | output    | out_valid_o / out_stall_i  | tsie_pkg::result_t
//
// one token is taken per cycle while in_stall_o is low; its parse and result group complete at that edge
// each result leaves in its own cycle, so a token yields 0 to 3 results
// the two-entry group queue sets the input stall: in_stall_o is high while it is full
// the result group of a token is registered in the queue; its first result shows once it is at the head
// reset clears parse state, address count, halt flag and the queue; no clearing pass
module token_stream_instruction_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsie_pkg::token_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsie_pkg::result_t  out_data_o
);

  logic             accept;
  logic             push;
  logic             full;
  tsie_pkg::group_t group;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // token parser
  tsie_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .token_i  (in_data_i),
    .push_o   (push),
    .group_o  (group)
  );

  // result queue and sequencer
  tsie_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .group_i     (group),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ test/tb_token_stream_instruction_encoder.sv @@
// tb_token_stream_instruction_encoder: self-checking testbench for the token stream encoder
// drives token transfers, predicts every result and checks it field by field
// depends on tsie_pkg and token_stream_instruction_encoder
`timescale 1ns / 100ps

module tb_token_stream_instruction_encoder;

  // token kind that the package does not name
  localparam logic [3:0] KindUnused = 4'd15;

  localparam int WatchdogLimit = 2000;

  // encoder state as the predictor keeps it
  typedef struct packed {
    tsie_pkg::state_e pstate;
    logic [3:0]       opcode;
    logic [5:0]       a_code;
    logic [2:0]       breg;
    logic [1:0][15:0] lit;
    logic [1:0]       lit_n;
    logic [15:0]      addr;
    logic             halted;
  } enc_ctx_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  tsie_pkg::token_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  tsie_pkg::result_t out_data_o;

  enc_ctx_t          ctx;
  tsie_pkg::result_t expected_words_q[$];
  tsie_pkg::token_t  stmt_q[$];
  bit                idle_on = 1'b1;
  int                error_count = 0;
  int                quiet_cycles = 0;

  token_stream_instruction_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // literal words of the current instruction, in operand order
  function automatic void push_literal(inout enc_ctx_t c, input logic [15:0] v);
    c.lit[c.lit_n[0]] = v;
    if (c.lit_n < tsie_pkg::MaxExtra) c.lit_n = c.lit_n + 2'd1;
  endfunction

  // parse one token, return the number of results it causes
  function automatic int encode_token(inout enc_ctx_t c, input tsie_pkg::token_t t,
                                      output tsie_pkg::result_t [2:0] grp);
    logic [2:0] reg_idx;
    logic [3:0] err;
    logic       done;
    logic       second;
    logic [5:0] opd;
    int         n;
    int         k;
    grp = '0;
    reg_idx = t.code[2:0];
    err = tsie_pkg::StatusWord;
    done = 1'b0;
    opd = '0;
    second = (c.pstate >= tsie_pkg::StBOpen);
    if (c.halted) return 0;
    case (c.pstate)
      tsie_pkg::StStart: begin
        if (t.kind == tsie_pkg::KindEnd) begin
          grp[0] = {16'h0000, c.addr, tsie_pkg::StatusEnd, 1'b1};
          return 1;
        end else if (t.kind == tsie_pkg::KindColon) begin
          c.pstate = tsie_pkg::StLabel;
        end else if (t.kind == tsie_pkg::KindOpcode && t.code != '0) begin
          c.opcode = t.code;
          c.lit_n = '0;
          c.pstate = tsie_pkg::StAOpen;
        end else begin
          err = tsie_pkg::ErrStmt;
        end
      end
      tsie_pkg::StLabel: begin
        if (t.kind == tsie_pkg::KindName) c.pstate = tsie_pkg::StStart;
        else err = tsie_pkg::ErrLabel;
      end
      tsie_pkg::StComma: begin
        if (t.kind == tsie_pkg::KindComma) c.pstate = tsie_pkg::StBOpen;
        else err = tsie_pkg::ErrComma;
      end
      tsie_pkg::StAOpen, tsie_pkg::StBOpen: begin
        if (t.kind == tsie_pkg::KindReg) begin
          done = 1'b1;
          opd = {3'b000, reg_idx};
        end else if (t.kind >= tsie_pkg::KindPop && t.kind <= tsie_pkg::KindO) begin
          done = 1'b1;
          opd = tsie_pkg::OpdPop + 6'(t.kind - tsie_pkg::KindPop);
        end else if (t.kind == tsie_pkg::KindNumber) begin
          push_literal(c, t.number);
          done = 1'b1;
          opd = tsie_pkg::OpdLit;
        end else if (t.kind == tsie_pkg::KindLbrack) begin
          c.pstate = tsie_pkg::state_e'(c.pstate + 4'd1);
        end else begin
          err = tsie_pkg::ErrBrack;
        end
      end
      tsie_pkg::StABrack, tsie_pkg::StBBrack: begin
        if (t.kind == tsie_pkg::KindReg) begin
          c.breg = reg_idx;
          c.pstate = tsie_pkg::state_e'(c.pstate + 4'd1);
        end else if (t.kind == tsie_pkg::KindNumber) begin
          push_literal(c, t.number);
          c.pstate = tsie_pkg::state_e'(c.pstate + 4'd4);
        end else begin
          err = tsie_pkg::ErrOper;
        end
      end
      tsie_pkg::StABreg, tsie_pkg::StBBreg: begin
        if (t.kind == tsie_pkg::KindRbrack) begin
          done = 1'b1;
          opd = tsie_pkg::OpdRegInd | {3'b000, c.breg};
        end else if (t.kind == tsie_pkg::KindComma) begin
          c.pstate = tsie_pkg::state_e'(c.pstate + 4'd1);
        end else begin
          err = tsie_pkg::ErrOper;
        end
      end
      tsie_pkg::StABregc, tsie_pkg::StBBregc: begin
        if (t.kind == tsie_pkg::KindNumber) begin
          push_literal(c, t.number);
          c.pstate = tsie_pkg::state_e'(c.pstate + 4'd1);
        end else begin
          err = tsie_pkg::ErrNumber;
        end
      end
      tsie_pkg::StABregn, tsie_pkg::StBBregn: begin
        if (t.kind == tsie_pkg::KindRbrack) begin
          done = 1'b1;
          opd = tsie_pkg::OpdRegOfs | {3'b000, c.breg};
        end else begin
          err = tsie_pkg::ErrClose;
        end
      end
      tsie_pkg::StABnum, tsie_pkg::StBBnum: begin
        if (t.kind == tsie_pkg::KindRbrack) begin
          done = 1'b1;
          opd = tsie_pkg::OpdLitInd;
        end else if (t.kind == tsie_pkg::KindReg) begin
          done = 1'b1;
          opd = tsie_pkg::OpdRegOfs | {3'b000, reg_idx};
        end else begin
          err = tsie_pkg::ErrOper;
        end
      end
      default: begin
        err = tsie_pkg::ErrStmt;
        c.pstate = tsie_pkg::StStart;
      end
    endcase

    // a syntax error reports once and halts
    if (err != tsie_pkg::StatusWord) begin
      grp[0] = {16'h0000, c.addr, err, 1'b1};
      c.halted = 1'b1;
      return 1;
    end
    if (!done) return 0;
    if (!second) begin
      c.a_code = opd;
      c.pstate = tsie_pkg::StComma;
      return 0;
    end

    // instruction word, then literal of operand a, then of operand b
    n = int'(c.lit_n);
    grp[0] = {opd, c.a_code, c.opcode, c.addr, tsie_pkg::StatusWord, n == 0};
    for (k = 0; k < n; k++)
      grp[k + 1] = {c.lit[k], c.addr + 16'(k + 1), tsie_pkg::StatusWord, k + 1 == n};
    c.addr = c.addr + 16'(n + 1);
    c.lit_n = '0;
    c.pstate = tsie_pkg::StStart;
    return n + 1;
  endfunction

  function automatic tsie_pkg::token_t tok(logic [3:0] kind, logic [3:0] code,
                                           logic [15:0] num);
    tsie_pkg::token_t t;
    t.kind = kind;
    t.code = code;
    t.number = num;
    return t;
  endfunction

  function automatic logic [15:0] rand_number();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // token of a given kind with random content; opcodes are nonzero
  function automatic tsie_pkg::token_t rand_token(logic [3:0] kind);
    tsie_pkg::token_t t;
    t = tok(kind, 4'($urandom), rand_number());
    if (kind == tsie_pkg::KindOpcode) t.code = 4'($urandom_range(1, 15));
    return t;
  endfunction

  // one operand in any of its forms
  function automatic void add_operand();
    int form;
    form = $urandom_range(0, 11);
    case (form)
      0: stmt_q.push_back(rand_token(tsie_pkg::KindReg));
      1, 2, 3, 4, 5, 6: stmt_q.push_back(rand_token(tsie_pkg::KindPop + 4'(form - 1)));
      7: stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
      8: begin
        stmt_q.push_back(rand_token(tsie_pkg::KindLbrack));
        stmt_q.push_back(rand_token(tsie_pkg::KindReg));
        stmt_q.push_back(rand_token(tsie_pkg::KindRbrack));
      end
      9: begin
        stmt_q.push_back(rand_token(tsie_pkg::KindLbrack));
        stmt_q.push_back(rand_token(tsie_pkg::KindReg));
        stmt_q.push_back(rand_token(tsie_pkg::KindComma));
        stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
        stmt_q.push_back(rand_token(tsie_pkg::KindRbrack));
      end
      10: begin
        stmt_q.push_back(rand_token(tsie_pkg::KindLbrack));
        stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
        stmt_q.push_back(rand_token(tsie_pkg::KindRbrack));
      end
      default: begin
        stmt_q.push_back(rand_token(tsie_pkg::KindLbrack));
        stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
        stmt_q.push_back(rand_token(tsie_pkg::KindReg));
      end
    endcase
  endfunction

  function automatic void build_instruction();
    stmt_q.delete();
    stmt_q.push_back(rand_token(tsie_pkg::KindOpcode));
    add_operand();
    stmt_q.push_back(rand_token(tsie_pkg::KindComma));
    add_operand();
  endfunction

  // one token transfer, with an optional gap before it
  task automatic send_token(input tsie_pkg::token_t t);
    tsie_pkg::result_t [2:0] grp;
    int                      n;
    int                      k;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    n = encode_token(ctx, t, grp);
    for (k = 0; k < n; k++) expected_words_q.push_back(grp[k]);
  endtask

  task automatic send_stmt();
    int i;
    for (i = 0; i < stmt_q.size(); i++) send_token(stmt_q[i]);
  endtask

  // hold the sender until every expected result has come
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input tsie_pkg::result_t want,
                                 input tsie_pkg::result_t got);
    $display("%0t ERROR %s: want word %h addr %h status %0d last %0b, got %h %h %0d %0b",
             $time, what, want.word, want.address, want.status, want.last,
             got.word, got.address, got.status, got.last);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    tsie_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data_o);
      end else begin
        want = expected_words_q.pop_front();
        if (out_data_o.word !== want.word) report_mismatch("word", want, out_data_o);
        if (out_data_o.address !== want.address)
          report_mismatch("address", want, out_data_o);
        if (out_data_o.status !== want.status) report_mismatch("status", want, out_data_o);
        if (out_data_o.last !== want.last) report_mismatch("last", want, out_data_o);
      end
    end
  end

  // receiver stall bursts with free stretches between them
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("token_stream_instruction_encoder: mismatch");
        $finish;
      end
    end
  end

  // end at address zero, a label, and each bracketed operand form
  task automatic test_directed();
    send_token(tok(tsie_pkg::KindEnd, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindColon, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindName, 4'd15, 16'hffff));
    // register code above seven uses the low three bits
    send_token(tok(tsie_pkg::KindOpcode, 4'd1, 16'h0000));
    send_token(tok(tsie_pkg::KindReg, 4'd15, 16'hffff));
    send_token(tok(tsie_pkg::KindComma, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindPop, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindOpcode, 4'd15, 16'hffff));
    send_token(tok(tsie_pkg::KindLbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindNumber, 4'd0, 16'hffff));
    send_token(tok(tsie_pkg::KindRbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindComma, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindLbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindReg, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindComma, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindNumber, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindRbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindOpcode, 4'd8, 16'h0000));
    send_token(tok(tsie_pkg::KindLbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindReg, 4'd3, 16'h0000));
    send_token(tok(tsie_pkg::KindRbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindComma, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindLbrack, 4'd0, 16'h0000));
    send_token(tok(tsie_pkg::KindNumber, 4'd0, 16'h8000));
    send_token(tok(tsie_pkg::KindReg, 4'd13, 16'h0000));
    send_token(tok(tsie_pkg::KindEnd, 4'd0, 16'h0000));
  endtask

  // well-formed statements only: any syntax error halts until reset
  task automatic test_random_statements();
    int  sent;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    while (sent < 240) begin
      case ($urandom_range(0, 9))
        0: begin
          stmt_q.delete();
          stmt_q.push_back(rand_token(tsie_pkg::KindColon));
          stmt_q.push_back(rand_token(tsie_pkg::KindName));
        end
        1: begin
          stmt_q.delete();
          stmt_q.push_back(rand_token(tsie_pkg::KindEnd));
        end
        default: build_instruction();
      endcase
      send_stmt();
      sent += stmt_q.size();
      if (!paused && sent >= 120) begin
        paused = 1'b1;
        wait_results_done();
      end
    end
  endtask

  // mostly three-word instructions with no idling on either side
  task automatic test_back_to_back();
    int i;
    idle_on = 1'b0;
    for (i = 0; i < 10; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        build_instruction();
      end else begin
        stmt_q.delete();
        stmt_q.push_back(rand_token(tsie_pkg::KindOpcode));
        stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
        stmt_q.push_back(rand_token(tsie_pkg::KindComma));
        stmt_q.push_back(rand_token(tsie_pkg::KindNumber));
      end
      send_stmt();
    end
    send_token(rand_token(tsie_pkg::KindEnd));
  endtask

  // a statement broken at a random point, then tokens that must be ignored
  task automatic test_error_halt();
    enc_ctx_t                trial;
    tsie_pkg::token_t        bad;
    tsie_pkg::result_t [2:0] grp;
    int                      cut;
    int                      i;
    build_instruction();
    cut = $urandom_range(0, stmt_q.size() - 1);
    for (i = 0; i < cut; i++) send_token(stmt_q[i]);
    // pick a token that is wrong here: end, zero opcode, unused kind or anything
    do begin
      case ($urandom_range(0, 3))
        0: bad = rand_token(tsie_pkg::KindEnd);
        1: begin
          bad = rand_token(tsie_pkg::KindOpcode);
          bad.code = '0;
        end
        2: bad = rand_token(KindUnused);
        default: bad = rand_token(4'($urandom));
      endcase
      trial = ctx;
      void'(encode_token(trial, bad, grp));
    end while (!trial.halted);
    send_token(bad);
    for (i = 0; i < 8; i++) send_token(rand_token(4'($urandom)));
    send_token(rand_token(tsie_pkg::KindEnd));
  endtask

  // sequence
  initial begin
    ctx = '0;
    ctx.pstate = tsie_pkg::StStart;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_results_done();
    test_random_statements();
    wait_results_done();
    test_back_to_back();
    wait_results_done();
    test_error_halt();
    wait_results_done();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("token_stream_instruction_encoder: match");
    end else begin
      $display("token_stream_instruction_encoder: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tsie_pkg.sv
rtl/tsie_parser.sv
rtl/tsie_out_queue.sv
rtl/token_stream_instruction_encoder.sv
test/tb_token_stream_instruction_encoder.sv
